// ----- design/laplacian_sharpen_3x3_stream_assert.svh -----
// assertion macros for the laplacian sharpening stream block
// no dependencies; included by the top level, the only file that carries concurrent checks
`ifndef LAPLACIAN_SHARPEN_3X3_STREAM_ASSERT_SVH
`define LAPLACIAN_SHARPEN_3X3_STREAM_ASSERT_SVH

// condition must hold on every clock out of reset
`define LSS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define LSS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lss_pkg.sv -----
// shared types and constants for the laplacian sharpening stream block
// no dependencies; used by the top level and the kernel
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;
    localparam int FW_W       = 12;
    localparam int FH_W       = 12;
    localparam int CH_W       = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 8'd2;

    // register reset values
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST   = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST  = 12'd480;
    localparam logic [CH_W-1:0] CHANNEL_COUNT_RST = 3'd3;

    // op codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic             valid_res;
        logic [PIX_W-1:0] pixel_out;
        logic             last;
    } result_t;

    // control and payload of the request waiting on line store data
    typedef struct packed {
        logic             res_valid;
        logic             last;
        logic             interior;
        logic [PIX_W-1:0] bot;
    } stage_t;

    // the five kernel taps of one sample
    typedef struct packed {
        logic             interior;
        logic [PIX_W-1:0] centre;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] down;
    } taps_t;

endpackage

`default_nettype wire

// ----- design/lss_linebuf.sv -----
// two line stores (rows two and one above the incoming row)
// no package dependency; read data registered, write-to-read forwarding
`timescale 1ns / 1ps
`default_nettype none

module lss_linebuf #(
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_bot,
    output logic [7:0]               top_q,
    output logic [7:0]               mid_q
);

    logic [7:0] upper_mem  [0:DEPTH-1];
    logic [7:0] middle_mem [0:DEPTH-1];
    logic       fwd;

    assign fwd = wr_en && (wr_addr == rd_addr);

    // upper takes the middle byte read for the same column, middle takes the new byte
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= mid_q;
            middle_mem[wr_addr] <= wr_bot;
        end
        if (rd_en)
        begin
            if (fwd)
            begin
                top_q <= mid_q;
                mid_q <= wr_bot;
            end
            else
            begin
                top_q <= upper_mem[rd_addr];
                mid_q <= middle_mem[rd_addr];
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/lss_kernel.sv -----
// 3x3 laplacian sharpening kernel: 5*centre minus four neighbours, saturated, 0 off the interior
// depends on lss_pkg for the tap struct
`timescale 1ns / 1ps
`default_nettype none

module lss_kernel (
    input  lss_pkg::taps_t                taps,
    output logic [lss_pkg::PIX_W-1:0]     pixel
);

    logic        [10:0] five_c;
    logic        [9:0]  ring;
    logic signed [11:0] diff;

    always_comb
    begin
        five_c = {1'b0, taps.centre, 2'b00} + {3'b000, taps.centre};
        ring   = {2'b00, taps.left} + {2'b00, taps.right}
               + {2'b00, taps.up} + {2'b00, taps.down};
        diff   = $signed({1'b0, five_c}) - $signed({2'b00, ring});
        if (!taps.interior || diff < 12'sd0)
            pixel = '0;
        else if (diff > 12'sd255)
            pixel = 8'hFF;
        else
            pixel = diff[7:0];
    end

endmodule

`default_nettype wire

// ----- design/laplacian_sharpen_3x3_stream.sv -----
// top level of the streaming 3x3 laplacian sharpening filter
// depends on lss_pkg, lss_linebuf, lss_kernel and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

// Channel-interleaved 8-bit samples enter in raster order, up to one request per clock,
// and every request gives exactly one result: 5*centre minus the left, right, up
// and down neighbours of the same channel, saturated to 0..255, or 0 on the frame
// border. The result for a sample leaves on the request that arrives one line plus
// one pixel later (frame_width*channel_count + channel_count requests). The frame
// closes channel_count requests after its final sample, so that many flush
// requests (op = 1) follow the image; last marks the closing request, after which
// the next request starts a new frame. The border results of the final image row
// are never sent. Throughput is one request per cycle, with no gaps while
// result_stall stays low: the two line stores are each read and written once per
// cycle, and a result moves from stage 1 to the output register (line store read on
// acceptance, kernel on the way out). While a result waits under result_stall the
// block still takes one more request, then stalls its input. The line stores are
// not cleared after reset; any stale bytes only reach border positions, which
// give 0. Configuration writes are accepted at any time (cfg_ready is tied high)
// but belong to idle periods; a write to a known register restarts the frame.
// Out-of-range settings are clamped: width to 3..MAX_WIDTH, height to at least 3,
// channels to 1..MAX_CHANNELS.
module laplacian_sharpen_3x3_stream #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample requests
    input  logic                                item_valid,
    output logic                                item_stall,
    input  lss_pkg::item_t                      item,
    // results
    output logic                                result_valid,
    input  logic                                result_stall,
    output lss_pkg::result_t                    result,
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lss_pkg::CFG_DATA_W-1:0]      cfg_data
);

`include "laplacian_sharpen_3x3_stream_assert.svh"

    localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW         = $clog2(LINE_DEPTH);
    localparam int SW         = AW + 1;                      // holds the row sample count
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int CHW        = $clog2(MAX_CHANNELS + 1);
    localparam int RW         = lss_pkg::ROW_W;

    // ---------------------------------------------------------------- registers
    logic [lss_pkg::FW_W-1:0] frame_width_reg;
    logic [lss_pkg::FH_W-1:0] frame_height_reg;
    logic [lss_pkg::CH_W-1:0] channel_count_reg;
    logic                     cfg_we;
    logic                     restart;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // only writes to a known register restart the frame
    always_comb
    begin
        restart = cfg_we && (cfg_index inside {lss_pkg::CFG_FRAME_WIDTH,
                                               lss_pkg::CFG_FRAME_HEIGHT,
                                               lss_pkg::CFG_CHANNEL_COUNT});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= lss_pkg::FRAME_WIDTH_RST;
            frame_height_reg  <= lss_pkg::FRAME_HEIGHT_RST;
            channel_count_reg <= lss_pkg::CHANNEL_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lss_pkg::CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_data;
                lss_pkg::CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data;
                lss_pkg::CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[lss_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------- effective geometry
    logic [WW-1:0]  eff_w;
    logic [CHW-1:0] eff_ch;
    logic [RW-1:0]  eff_h;
    logic [SW-1:0]  row_samples;

    always_comb
    begin
        if (int'(frame_width_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else if (frame_width_reg < 12'd3)
            eff_w = WW'(3);
        else
            eff_w = WW'(frame_width_reg);

        if (channel_count_reg == 3'd0)
            eff_ch = CHW'(1);
        else if (int'(channel_count_reg) > MAX_CHANNELS)
            eff_ch = CHW'(MAX_CHANNELS);
        else
            eff_ch = CHW'(channel_count_reg);

        eff_h       = (frame_height_reg < 12'd3) ? RW'(3) : frame_height_reg;
        row_samples = SW'(eff_w) * SW'(eff_ch);
    end

    // ------------------------------------------------------------ handshakes
    logic accept;
    logic out_free;
    logic s1_move;
    logic s1_valid_reg;
    logic out_valid_reg;

    // output register frees when empty or when its result is taken
    assign out_free     = !out_valid_reg || !result_stall;
    assign s1_move      = s1_valid_reg && out_free;
    assign item_stall   = s1_valid_reg && !out_free;
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;

    // ------------------------------------------------------- position counters
    logic [AW-1:0]  si_reg, si_next;
    logic [RW-1:0]  ri_reg, ri_next;
    logic [SW-1:0]  si_ext;
    logic [SW-1:0]  si_inc;
    logic [RW:0]    ri_inc;
    logic           cur_last;
    logic           cur_valid;
    logic           cur_interior;

    always_comb
    begin
        si_ext = SW'(si_reg);
        si_inc = si_ext + SW'(1);
        ri_inc = {1'b0, ri_reg} + (RW+1)'(1);

        // result of the sample one line plus one pixel back
        cur_valid = (ri_reg >= RW'(2)) || (ri_reg == RW'(1) && si_ext >= SW'(eff_ch));
        // centre row is neither the first nor the last, centre column likewise
        cur_interior = (ri_reg >= RW'(2)) && (ri_inc <= {1'b0, eff_h})
                    && (si_ext >= (SW'(eff_ch) << 1));
        // first pixel of the row after the last image row closes the frame
        cur_last = (ri_reg == eff_h) && (si_ext == SW'(eff_ch) - SW'(1));

        if (cur_last)
        begin
            si_next = '0;
            ri_next = '0;
        end
        else if (si_inc >= row_samples)
        begin
            si_next = '0;
            ri_next = ri_inc[RW-1:0];
        end
        else
        begin
            si_next = si_inc[AW-1:0];
            ri_next = ri_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            si_reg <= '0;
            ri_reg <= '0;
        end
        else if (restart)
        begin
            si_reg <= '0;
            ri_reg <= '0;
        end
        else if (accept)
        begin
            si_reg <= si_next;
            ri_reg <= ri_next;
        end
    end

    // ------------------------------------------ stage 1: waiting on line stores
    lss_pkg::stage_t s1_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic [7:0]      top_q;
    logic [7:0]      mid_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    // flush requests enter as zero samples
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.res_valid <= cur_valid;
            s1_reg.last      <= cur_last;
            s1_reg.interior  <= cur_interior;
            s1_reg.bot       <= (item.op == lss_pkg::OP_FLUSH) ? 8'h00 : item.sample;
            s1_addr_reg      <= si_reg;
        end
    end

    // column reads on accept, column write-back as the request moves on
    lss_linebuf #(
        .DEPTH (LINE_DEPTH)
    ) u_linebuf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (si_reg),
        .wr_en   (s1_move),
        .wr_addr (s1_addr_reg),
        .wr_bot  (s1_reg.bot),
        .top_q   (top_q),
        .mid_q   (mid_q)
    );

    // ------------------------------------------------------ neighbour windows
    // middle-row bytes and the up/down bytes of the previous samples, newest first
    logic [7:0] cw_reg [0:2*MAX_CHANNELS-1];
    logic [7:0] up_reg [0:MAX_CHANNELS-1];
    logic [7:0] dn_reg [0:MAX_CHANNELS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2*MAX_CHANNELS; i++)
                cw_reg[i] <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                up_reg[i] <= '0;
                dn_reg[i] <= '0;
            end
        end
        else if (restart)
        begin
            for (int i = 0; i < 2*MAX_CHANNELS; i++)
                cw_reg[i] <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                up_reg[i] <= '0;
                dn_reg[i] <= '0;
            end
        end
        else if (s1_move)
        begin
            cw_reg[0] <= mid_q;
            for (int i = 1; i < 2*MAX_CHANNELS; i++)
                cw_reg[i] <= cw_reg[i-1];
            up_reg[0] <= top_q;
            dn_reg[0] <= s1_reg.bot;
            for (int i = 1; i < MAX_CHANNELS; i++)
            begin
                up_reg[i] <= up_reg[i-1];
                dn_reg[i] <= dn_reg[i-1];
            end
        end
    end

    // taps one pixel and two pixels back in the same channel
    lss_pkg::taps_t taps;

    always_comb
    begin
        taps.interior = s1_reg.interior;
        taps.right    = mid_q;
        taps.centre   = cw_reg[0];
        taps.left     = cw_reg[1];
        taps.up       = up_reg[0];
        taps.down     = dn_reg[0];
        for (int k = 1; k <= MAX_CHANNELS; k++)
        begin
            if (eff_ch == CHW'(k))
            begin
                taps.centre = cw_reg[k-1];
                taps.left   = cw_reg[2*k-1];
                taps.up     = up_reg[k-1];
                taps.down   = dn_reg[k-1];
            end
        end
    end

    logic [lss_pkg::PIX_W-1:0] pixel;

    lss_kernel u_kernel (
        .taps  (taps),
        .pixel (pixel)
    );

    // ------------------------------------------------------- output register
    lss_pkg::result_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_reg.valid_res <= s1_reg.res_valid;
            out_reg.pixel_out <= pixel;
            out_reg.last      <= s1_reg.last;
        end
    end

    assign result = out_reg;

    // ------------------------------------------------------------ assertions
    `LSS_ASSERT_NEXT(a_frame_wrap, clk, rst_n, accept && cur_last && !restart,
        si_reg == '0 && ri_reg == '0, "positions did not return to zero after last")
    `LSS_ASSERT_ALWAYS(a_col_range, clk, rst_n, SW'(si_reg) < row_samples,
        "sample position beyond the row")
    `LSS_ASSERT_ALWAYS(a_row_range, clk, rst_n, ri_reg <= eff_h,
        "row position beyond the flush row")
    `LSS_ASSERT_IMPLIES(a_interior_valid, clk, rst_n, s1_valid_reg && s1_reg.interior,
        s1_reg.res_valid, "interior result flagged before the latency has passed")

endmodule

`default_nettype wire
